FILE: rtl/wpts_pkg.sv
// shared types and constants for the world point to screen unit
// no dependencies
package wpts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int HALF_W        = 14;
    localparam int QUOT_W        = 32;

    localparam logic [63:0] X_PXPY_RST  = 64'd65536;
    localparam logic [63:0] X_PZOFF_RST = 64'd0;
    localparam logic [63:0] Y_PXPY_RST  = 64'd65536 << 32;
    localparam logic [63:0] Y_PZOFF_RST = 64'd0;
    localparam logic [63:0] W_PXPY_RST  = 64'd0;
    localparam logic [63:0] W_PZOFF_RST = 64'd65536 << 32;
    localparam logic [14:0] VP_W_RST    = 15'd640;
    localparam logic [14:0] VP_H_RST    = 15'd480;

    // register map, one 64-bit slot each
    typedef enum logic [2:0] {
        REG_X_PXPY  = 3'd0,
        REG_X_PZOFF = 3'd1,
        REG_Y_PXPY  = 3'd2,
        REG_Y_PZOFF = 3'd3,
        REG_W_PXPY  = 3'd4,
        REG_W_PZOFF = 3'd5,
        REG_VP_W    = 3'd6,
        REG_VP_H    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] cpx;
        logic signed [31:0] cpy;
        logic signed [31:0] cpz;
        logic signed [31:0] off;
    } wpts_col_t;

    typedef struct packed {
        wpts_col_t x;
        wpts_col_t y;
        wpts_col_t w;
    } wpts_coef_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               w_zero;
    } wpts_res_t;

endpackage

FILE: rtl/wpts_clip.sv
// clip-space transform: input register, nine products, shifted sum
// depends on wpts_pkg
module wpts_clip #(
    parameter int FRAC_BITS = wpts_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [31:0]        px,
    input  logic signed [31:0]        py,
    input  logic signed [31:0]        pz,
    input  wpts_pkg::wpts_coef_t      coef,
    output logic                      out_valid,
    output logic signed [65-FRAC_BITS:0] cx,
    output logic signed [65-FRAC_BITS:0] cy,
    output logic signed [65-FRAC_BITS:0] cw
);
    import wpts_pkg::*;

    localparam int CLIP_W = 66 - FRAC_BITS;
    localparam int SH_W   = 64 - FRAC_BITS;

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [63:0] mul_reg [9];
    logic signed [SH_W-1:0] sh [9];
    logic signed [CLIP_W-1:0] cx_reg, cy_reg, cw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg     <= px;
            py_reg     <= py;
            pz_reg     <= pz;
            mul_reg[0] <= coef.x.cpx * px_reg;
            mul_reg[1] <= coef.x.cpy * py_reg;
            mul_reg[2] <= coef.x.cpz * pz_reg;
            mul_reg[3] <= coef.y.cpx * px_reg;
            mul_reg[4] <= coef.y.cpy * py_reg;
            mul_reg[5] <= coef.y.cpz * pz_reg;
            mul_reg[6] <= coef.w.cpx * px_reg;
            mul_reg[7] <= coef.w.cpy * py_reg;
            mul_reg[8] <= coef.w.cpz * pz_reg;
            cx_reg <= CLIP_W'(sh[0]) + CLIP_W'(sh[1]) + CLIP_W'(sh[2]) + CLIP_W'(coef.x.off);
            cy_reg <= CLIP_W'(sh[3]) + CLIP_W'(sh[4]) + CLIP_W'(sh[5]) + CLIP_W'(coef.y.off);
            cw_reg <= CLIP_W'(sh[6]) + CLIP_W'(sh[7]) + CLIP_W'(sh[8]) + CLIP_W'(coef.w.off);
        end
    end

    // arithmetic shift gives the floor of the scaled product
    for (genvar i = 0; i < 9; i++) begin : g_sh
        assign sh[i] = SH_W'(mul_reg[i] >>> FRAC_BITS);
    end

    assign out_valid = v3_reg;
    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign cw        = cw_reg;

endmodule

FILE: rtl/wpts_pix.sv
// pixel mapping: (w + c) * half / w with a one-bit-per-stage divider
// depends on wpts_pkg
module wpts_pix #(
    parameter int FRAC_BITS = wpts_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [65-FRAC_BITS:0] c,
    input  logic signed [65-FRAC_BITS:0] w,
    input  logic [wpts_pkg::HALF_W-1:0]  half,
    output logic                         out_valid,
    output logic signed [31:0]           res,
    output logic                         w_zero
);
    import wpts_pkg::*;

    localparam int CLIP_W = 66 - FRAC_BITS;
    localparam int MAG_W  = CLIP_W + 1;
    localparam int HI_W   = MAG_W - 32;
    localparam int NUM_W  = MAG_W + HALF_W;

    // stage one: sum, sign and magnitudes
    logic signed [MAG_W-1:0] n_s;
    logic                    v1_reg, neg1_reg, z1_reg;
    logic [MAG_W-1:0]        mag1_reg, d1_reg;
    // stage two: partial products
    logic                    v2_reg, neg2_reg, z2_reg;
    logic [MAG_W-1:0]        d2_reg;
    logic [31+HALF_W:0]      plo_reg;
    logic [HI_W+HALF_W-1:0]  phi_reg;
    // stage three: numerator, overflow check
    logic [NUM_W-1:0]        num_s;
    // divider stages, index 0 is the entry
    logic                    dv_reg   [QUOT_W+1];
    logic                    dneg_reg [QUOT_W+1];
    logic                    dz_reg   [QUOT_W+1];
    logic                    dbig_reg [QUOT_W+1];
    logic [MAG_W-1:0]        dd_reg   [QUOT_W+1];
    logic [MAG_W-1:0]        drem_reg [QUOT_W+1];
    logic [31:0]             dlo_reg  [QUOT_W+1];
    logic [QUOT_W-1:0]       dq_reg   [QUOT_W+1];
    // output
    logic                    vo_reg, zo_reg;
    logic signed [31:0]      res_reg;
    logic signed [31:0]      res_next;
    logic [QUOT_W-1:0]       qf;

    assign n_s   = MAG_W'(c) + MAG_W'(w);
    assign num_s = NUM_W'(plo_reg) + (NUM_W'(phi_reg) << 32);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= n_s[MAG_W-1] ^ w[CLIP_W-1];
            z1_reg   <= (w == '0);
            mag1_reg <= n_s[MAG_W-1] ? MAG_W'(-n_s) : MAG_W'(n_s);
            d1_reg   <= w[CLIP_W-1] ? MAG_W'(-MAG_W'(w)) : MAG_W'(w);

            neg2_reg <= neg1_reg;
            z2_reg   <= z1_reg;
            d2_reg   <= d1_reg;
            plo_reg  <= (32+HALF_W)'(mag1_reg[31:0]) * (32+HALF_W)'(half);
            phi_reg  <= (HI_W+HALF_W)'(mag1_reg[MAG_W-1:32]) * (HI_W+HALF_W)'(half);

            dneg_reg[0] <= neg2_reg;
            dz_reg[0]   <= z2_reg;
            dd_reg[0]   <= d2_reg;
            // quotient of 2^32 or more saturates
            dbig_reg[0] <= (MAG_W'(num_s[NUM_W-1:32]) >= d2_reg);
            drem_reg[0] <= MAG_W'(num_s[NUM_W-1:32]);
            dlo_reg[0]  <= num_s[31:0];
            dq_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_div
        logic [MAG_W:0] trial;
        logic           ge;
        assign trial = {drem_reg[k], dlo_reg[k][31]};
        assign ge    = (trial >= {1'b0, dd_reg[k]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dneg_reg[k+1] <= dneg_reg[k];
                dz_reg[k+1]   <= dz_reg[k];
                dbig_reg[k+1] <= dbig_reg[k];
                dd_reg[k+1]   <= dd_reg[k];
                drem_reg[k+1] <= ge ? MAG_W'(trial - {1'b0, dd_reg[k]}) : MAG_W'(trial);
                dlo_reg[k+1]  <= {dlo_reg[k][30:0], 1'b0};
                dq_reg[k+1]   <= {dq_reg[k][QUOT_W-2:0], ge};
            end
        end
    end

    assign qf = dq_reg[QUOT_W];

    always_comb begin
        if (dz_reg[QUOT_W]) begin
            res_next = '0;
        end else if (dneg_reg[QUOT_W]) begin
            if (dbig_reg[QUOT_W] || qf[31]) begin
                res_next = 32'sh8000_0000;
            end else begin
                res_next = -$signed(qf);
            end
        end else begin
            if (dbig_reg[QUOT_W] || (qf >= 32'h7FFF_FFFF)) begin
                res_next = 32'sh7FFF_FFFF;
            end else begin
                res_next = $signed(qf);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= dv_reg[QUOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
            zo_reg  <= dz_reg[QUOT_W];
        end
    end

    assign out_valid = vo_reg;
    assign res       = res_reg;
    assign w_zero    = zo_reg;

endmodule

FILE: rtl/world_point_to_screen_unit.sv
// world point to screen unit: projects a Q point to integer pixel coordinates
// a point passes the transform pipe, the pixel map pipes and the output register in turn
// throughput: one point per cycle unless stalled; fully pipelined multipliers, divider
// output word held in a two-entry output buffer so s_ready stays up while one waits
// reset (aresetn, synchronous, active low) empties the pipe and loads register defaults
// depends on wpts_pkg, wpts_clip, wpts_pix
module world_point_to_screen_unit #(
    parameter int FRAC_BITS = wpts_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // apb-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_screen_x,
    output logic signed [31:0] m_screen_y,
    output logic               m_w_is_zero
);
    import wpts_pkg::*;

    localparam int CLIP_W = 66 - FRAC_BITS;

    wpts_coef_t    coef_reg;
    logic [14:0]   vp_w_reg, vp_h_reg;
    reg_idx_t      idx;
    logic          wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {coef_reg.x.off, coef_reg.x.cpz} <= X_PZOFF_RST;
            {coef_reg.x.cpy, coef_reg.x.cpx} <= X_PXPY_RST;
            {coef_reg.y.off, coef_reg.y.cpz} <= Y_PZOFF_RST;
            {coef_reg.y.cpy, coef_reg.y.cpx} <= Y_PXPY_RST;
            {coef_reg.w.off, coef_reg.w.cpz} <= W_PZOFF_RST;
            {coef_reg.w.cpy, coef_reg.w.cpx} <= W_PXPY_RST;
            vp_w_reg <= VP_W_RST;
            vp_h_reg <= VP_H_RST;
        end else if (wr) begin
            case (idx)
                REG_X_PXPY:  {coef_reg.x.cpy, coef_reg.x.cpx} <= pwdata;
                REG_X_PZOFF: {coef_reg.x.off, coef_reg.x.cpz} <= pwdata;
                REG_Y_PXPY:  {coef_reg.y.cpy, coef_reg.y.cpx} <= pwdata;
                REG_Y_PZOFF: {coef_reg.y.off, coef_reg.y.cpz} <= pwdata;
                REG_W_PXPY:  {coef_reg.w.cpy, coef_reg.w.cpx} <= pwdata;
                REG_W_PZOFF: {coef_reg.w.off, coef_reg.w.cpz} <= pwdata;
                REG_VP_W:    vp_w_reg <= pwdata[14:0];
                REG_VP_H:    vp_h_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (idx)
            REG_X_PXPY:  prdata = {coef_reg.x.cpy, coef_reg.x.cpx};
            REG_X_PZOFF: prdata = {coef_reg.x.off, coef_reg.x.cpz};
            REG_Y_PXPY:  prdata = {coef_reg.y.cpy, coef_reg.y.cpx};
            REG_Y_PZOFF: prdata = {coef_reg.y.off, coef_reg.y.cpz};
            REG_W_PXPY:  prdata = {coef_reg.w.cpy, coef_reg.w.cpx};
            REG_W_PZOFF: prdata = {coef_reg.w.off, coef_reg.w.cpz};
            REG_VP_W:    prdata = 64'(vp_w_reg);
            REG_VP_H:    prdata = 64'(vp_h_reg);
            default:     prdata = '0;
        endcase
    end

    // whole pipe advances unless the output buffer is full
    logic                    en;
    logic                    clip_v;
    logic signed [CLIP_W-1:0] cx, cy, cw;
    logic                    pix_v, pix_vy, zx, zy;
    logic signed [31:0]      sx, sy;

    wpts_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .px        (s_point_x),
        .py        (s_point_y),
        .pz        (s_point_z),
        .coef      (coef_reg),
        .out_valid (clip_v),
        .cx        (cx),
        .cy        (cy),
        .cw        (cw)
    );

    // half sizes come from a plain right shift of the viewport registers
    wpts_pix #(.FRAC_BITS(FRAC_BITS)) u_pix_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (clip_v),
        .c         (cx),
        .w         (cw),
        .half      (vp_w_reg[14:1]),
        .out_valid (pix_v),
        .res       (sx),
        .w_zero    (zx)
    );

    wpts_pix #(.FRAC_BITS(FRAC_BITS)) u_pix_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (clip_v),
        .c         (cy),
        .w         (cw),
        .half      (vp_h_reg[14:1]),
        .out_valid (pix_vy),
        .res       (sy),
        .w_zero    (zy)
    );

    // output register plus skid entry
    wpts_res_t out_reg, skid_reg, new_res;
    logic      out_v_reg, skid_v_reg;
    logic      push, pop;

    assign en      = ~skid_v_reg;
    assign s_ready = en;
    // both lanes run in lock step, so either valid would do
    assign push    = en & pix_v & pix_vy;
    assign pop     = out_v_reg & m_ready;
    assign new_res = '{sx: sx, sy: sy, w_zero: zx & zy};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (skid_v_reg) begin
                if (pop) begin
                    skid_v_reg <= 1'b0;
                end
            end else if (push) begin
                if (!out_v_reg || pop) begin
                    out_v_reg <= 1'b1;
                end else begin
                    skid_v_reg <= 1'b1;
                end
            end else if (pop) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_v_reg || pop) begin
                out_reg <= new_res;
            end else begin
                skid_reg <= new_res;
            end
        end
    end

    assign m_valid     = out_v_reg;
    assign m_screen_x  = out_reg.sx;
    assign m_screen_y  = out_reg.sy;
    assign m_w_is_zero = out_reg.w_zero;

endmodule

FILE: tb/sv/tb_world_point_to_screen_unit.sv
// self-checking testbench for world_point_to_screen_unit: directed and random points
// over several register settings, each result checked against a built-in projector
// depends on wpts_pkg and the world_point_to_screen_unit rtl
module tb_world_point_to_screen_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import wpts_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int LIMIT     = 400000;
    localparam int RAND_PTS  = 86;
    localparam int N_PHASES  = 12;

    // projector and store of expected pixel words
    class screen_scoreboard;
        logic [63:0] coef [6];
        logic [14:0] vp_w, vp_h;
        wpts_res_t   expected_px [$];
        int          n_errors;

        function new();
            coef[REG_X_PXPY]  = X_PXPY_RST;
            coef[REG_X_PZOFF] = X_PZOFF_RST;
            coef[REG_Y_PXPY]  = Y_PXPY_RST;
            coef[REG_Y_PZOFF] = Y_PZOFF_RST;
            coef[REG_W_PXPY]  = W_PXPY_RST;
            coef[REG_W_PZOFF] = W_PZOFF_RST;
            vp_w = VP_W_RST;
            vp_h = VP_H_RST;
            n_errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [63:0] value);
            if (idx == REG_VP_W) vp_w = value[14:0];
            else if (idx == REG_VP_H) vp_h = value[14:0];
            else coef[idx] = value;
        endfunction

        // one clip coordinate: floored products plus offset
        function longint clip_coord(logic [63:0] pxpy, logic [63:0] pzoff,
                                    longint px, longint py, longint pz);
            longint acc;
            acc = longint'(signed'(pzoff[63:32]));
            acc += (longint'(signed'(pxpy[31:0])) * px) >>> FRAC;
            acc += (longint'(signed'(pxpy[63:32])) * py) >>> FRAC;
            acc += (longint'(signed'(pzoff[31:0])) * pz) >>> FRAC;
            return acc;
        endfunction

        // trunc((w + c) * half / w), saturated to 32 bits
        function logic [31:0] pixel_of(longint c, longint w, logic [13:0] half);
            longint      n;
            bit          neg;
            logic [63:0] un, ud;
            logic [127:0] q;
            n   = w + c;
            neg = (n < 0) != (w < 0);
            un  = n < 0 ? 64'(-n) : 64'(n);
            ud  = w < 0 ? 64'(-w) : 64'(w);
            q   = ({64'd0, un} * {114'd0, half}) / {64'd0, ud};
            if (neg) begin
                if (q >= 128'h8000_0000) return 32'h8000_0000;
                return -q[31:0];
            end
            if (q >= 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
            return q[31:0];
        endfunction

        function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            longint    px, py, pz, cx, cy, cw;
            wpts_res_t r;
            px = longint'(signed'(x));
            py = longint'(signed'(y));
            pz = longint'(signed'(z));
            cx = clip_coord(coef[REG_X_PXPY], coef[REG_X_PZOFF], px, py, pz);
            cy = clip_coord(coef[REG_Y_PXPY], coef[REG_Y_PZOFF], px, py, pz);
            cw = clip_coord(coef[REG_W_PXPY], coef[REG_W_PZOFF], px, py, pz);
            if (cw == 0) begin
                r.sx = '0;
                r.sy = '0;
                r.w_zero = 1'b1;
            end else begin
                r.sx = pixel_of(cx, cw, vp_w[14:1]);
                r.sy = pixel_of(cy, cw, vp_h[14:1]);
                r.w_zero = 1'b0;
            end
            expected_px.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            n_errors++;
        endtask

        task check_result(logic [31:0] sx, logic [31:0] sy, logic wz);
            wpts_res_t e;
            if (expected_px.size() == 0) begin
                report_mismatch("result word with nothing expected");
                return;
            end
            e = expected_px.pop_front();
            if (sx !== e.sx)
                report_mismatch($sformatf("screen_x %0d, expected %0d", sx, e.sx));
            if (sy !== e.sy)
                report_mismatch($sformatf("screen_y %0d, expected %0d", sy, e.sy));
            if (wz !== e.w_zero)
                report_mismatch($sformatf("w_is_zero %0b, expected %0b", wz, e.w_zero));
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_point_x = '0, s_point_y = '0, s_point_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_screen_x, m_screen_y;
    logic               m_w_is_zero;

    screen_scoreboard sb = new();
    bit               no_idle = 1'b0;   // long stretch with both sides always ready
    int unsigned      cycles = 0;

    world_point_to_screen_unit dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // monitor: note accepted points, check accepted pixel words
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_point(s_point_x, s_point_y, s_point_z);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_screen_x, m_screen_y, m_w_is_zero);
    end

    // receiver stalls about 29 percent of the time
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 29);
    end

    // apb write: setup then access, register written on the access edge
    task write_reg(reg_idx_t idx, logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 6'(8 * idx);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one point word, with a random gap of idle cycles in front
    task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task wait_drained();
        while (sb.expected_px.size() != 0) @(posedge aclk);
    endtask

    // coordinate: mostly modest world values, some full-range
    function logic [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom();
            default: return 32'($signed($urandom_range(2 * 1310720)) - 1310720);
        endcase
    endfunction

    // one q16.16 coefficient: small, full random or an extreme
    function logic [31:0] rand_coef();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return $urandom();
            default: return 32'($signed($urandom_range(2 * 262144)) - 262144);
        endcase
    endfunction

    function logic [14:0] rand_vp();
        case ($urandom_range(7))
            0:       return 15'd0;
            1:       return 15'd1;
            2:       return 15'd16384;
            3:       return 15'h7FFF;
            default: return 15'($urandom_range(1, 4096));
        endcase
    endfunction

    task set_random_regs(int phase);
        logic [31:0] w_off;
        // some settings zero the w offset and x/y terms, others keep a sane depth term
        w_off = (phase % 4 == 3) ? 32'h0 : 32'($urandom_range(1, 8) * 65536);
        write_reg(REG_X_PXPY, {rand_coef(), rand_coef()});
        write_reg(REG_X_PZOFF, {rand_coef(), rand_coef()});
        write_reg(REG_Y_PXPY, {rand_coef(), rand_coef()});
        write_reg(REG_Y_PZOFF, {rand_coef(), rand_coef()});
        if (phase % 4 == 3) begin
            write_reg(REG_W_PXPY, 64'h0);
            write_reg(REG_W_PZOFF, {w_off, $urandom_range(1) ? rand_coef() : 32'h0});
        end else begin
            write_reg(REG_W_PXPY, {$urandom_range(1) ? rand_coef() : 32'h0,
                                   $urandom_range(1) ? rand_coef() : 32'h0});
            write_reg(REG_W_PZOFF, {w_off, rand_coef()});
        end
        // upper bits beyond 15 are junk that the block must drop
        write_reg(REG_VP_W, {$urandom(), $urandom()} & ~64'h7FFF | 64'(rand_vp()));
        write_reg(REG_VP_H, {$urandom(), $urandom()} & ~64'h7FFF | 64'(rand_vp()));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset matrix: identity x/y, w = 1.0
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0);
        drop_valid();
        wait_drained();

        // directed: w always zero
        write_reg(REG_W_PZOFF, 64'h0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        drop_valid();
        wait_drained();

        // directed: w from z only, extremes of coefficients and viewport
        write_reg(REG_X_PXPY, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        write_reg(REG_X_PZOFF, {32'h7FFF_FFFF, 32'h0});
        write_reg(REG_Y_PXPY, {32'h8000_0000, 32'h8000_0000});
        write_reg(REG_Y_PZOFF, {32'h8000_0000, 32'h0});
        write_reg(REG_W_PXPY, 64'h0);
        write_reg(REG_W_PZOFF, {32'h0, 32'h0001_0000});
        write_reg(REG_VP_W, 64'h7FFF);
        write_reg(REG_VP_H, 64'h1);
        send_point(32'h0, 32'h0, 32'h0);              // zero w via z
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
        send_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
        send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
        drop_valid();
        wait_drained();
        write_reg(REG_VP_W, 64'h0);
        write_reg(REG_VP_H, 64'h4000);
        send_point(32'h0004_0000, 32'hFFFC_0000, 32'h0002_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_0000);
        drop_valid();
        wait_drained();

        // random phases; the middle phase runs with no idling on either side
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_random_regs(ph);
            no_idle = (ph == N_PHASES / 2);
            for (int i = 0; i < RAND_PTS; i++)
                send_point(rand_coord(), rand_coord(), rand_coord());
            drop_valid();
            wait_drained();
            no_idle = 1'b0;
        end

        repeat (100) @(posedge aclk);
        if (sb.n_errors == 0 && sb.expected_px.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
rtl/wpts_pkg.sv
rtl/wpts_clip.sv
rtl/wpts_pix.sv
rtl/world_point_to_screen_unit.sv
tb/sv/tb_world_point_to_screen_unit.sv
